FILE: rtl/core/pmcc_pkg.sv
// shared constants, codes and types of the collision mask checker
package pmcc_pkg;

	localparam int MAX_MASK_WIDTH  = 1024;
	localparam int MAX_MASK_HEIGHT = 1024;
	localparam int MEM_DEPTH       = MAX_MASK_WIDTH * MAX_MASK_HEIGHT;
	localparam int COL_W           = $clog2(MAX_MASK_WIDTH);
	localparam int ROW_W           = $clog2(MAX_MASK_HEIGHT);
	localparam int ADDR_W          = $clog2(MEM_DEPTH);
	localparam int CRD_W           = 14;
	localparam int DIM_W           = 11;
	localparam int RESET_MASK_DIM  = 1024;

	localparam logic [2:0] DIR_LEFT  = 3'd0;
	localparam logic [2:0] DIR_RIGHT = 3'd1;
	localparam logic [2:0] DIR_UP    = 3'd2;
	localparam logic [2:0] DIR_DOWN  = 3'd3;

	localparam logic [1:0] CFG_MASK_WIDTH   = 2'd0;
	localparam logic [1:0] CFG_MASK_HEIGHT  = 2'd1;
	localparam logic [1:0] CFG_MASK_PRESENT = 2'd2;

	typedef enum logic [1:0] {
		FUNC_LOAD  = 2'd0,
		FUNC_QUERY = 2'd1,
		FUNC_MOVE  = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_SCAN,
		ST_LAST,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		func_t              func;
		logic signed [11:0] pos_x;
		logic signed [11:0] pos_y;
		logic [9:0]         rect_width;
		logic [9:0]         rect_height;
		logic [2:0]         move_dir;
		logic signed [10:0] move_amount;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
	} req_item_t;

	typedef struct packed {
		logic             we;
		logic [1:0]       index;
		logic [DIM_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic capture;
		logic write;
		logic start;
		logic step;
		logic load_imm;
		logic push;
	} dp_cmd_t;

	typedef struct packed {
		logic is_load;
		logic is_query;
		logic need_scan;
		logic scan_last;
		logic out_free;
	} dp_sts_t;

endpackage

FILE: rtl/core/pmcc_channels.sv
// valid/ready channel interfaces for items, results and register writes
interface pmcc_req_if;
	import pmcc_pkg::*;
	logic               valid;
	logic               ready;
	func_t              func;
	logic signed [11:0] pos_x;
	logic signed [11:0] pos_y;
	logic [9:0]         rect_width;
	logic [9:0]         rect_height;
	logic [2:0]         move_dir;
	logic signed [10:0] move_amount;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;

	modport source (
		output valid, func, pos_x, pos_y, rect_width, rect_height,
		output move_dir, move_amount, red, green, blue,
		input  ready
	);
	modport sink (
		input  valid, func, pos_x, pos_y, rect_width, rect_height,
		input  move_dir, move_amount, red, green, blue,
		output ready
	);
endinterface

interface pmcc_rsp_if;
	logic valid;
	logic ready;
	logic hit;

	modport source (output valid, hit, input ready);
	modport sink (input valid, hit, output ready);
endinterface

interface pmcc_cfg_if;
	import pmcc_pkg::*;
	logic             valid;
	logic             ready;
	logic [1:0]       index;
	logic [DIM_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/pmcc_ctrl.sv
// controller state machine sequencing load, setup, scan and result
module pmcc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pmcc_pkg::dp_sts_t sts,
	output pmcc_pkg::dp_cmd_t cmd
);
	import pmcc_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_SETUP;
				end
			end
			ST_SETUP: begin
				if (sts.is_load) begin
					cmd.write = 1'b1;
					state_nxt = ST_IDLE;
				end else if (!sts.is_query) begin
					state_nxt = ST_IDLE;
				end else if (sts.need_scan) begin
					cmd.start = 1'b1;
					state_nxt = ST_SCAN;
				end else begin
					cmd.load_imm = 1'b1;
					state_nxt    = ST_DONE;
				end
			end
			ST_SCAN: begin
				cmd.step = 1'b1;
				if (sts.scan_last) begin
					state_nxt = ST_LAST;
				end
			end
			ST_LAST: begin
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.push  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> sts.out_free)
		else $error("result pushed into a full output register");

	a_accept_setup: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid) |=> state_q == ST_SETUP)
		else $error("accepted item not followed by setup");

	a_scan_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && sts.scan_last) |=> state_q == ST_LAST)
		else $error("scan did not end after its last pixel");

endmodule

FILE: rtl/core/pmcc_dp.sv
// datapath: mask memory, registers, rectangle setup, scan counters and result
module pmcc_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  pmcc_pkg::req_item_t item,
	input  pmcc_pkg::cfg_wr_t   cfg_wr,
	input  pmcc_pkg::dp_cmd_t   cmd,
	output pmcc_pkg::dp_sts_t   sts,
	input  logic                rsp_ready,
	output logic                rsp_valid,
	output logic                rsp_hit
);
	import pmcc_pkg::*;

	req_item_t        item_q;
	logic [DIM_W-1:0] mask_width_q;
	logic [DIM_W-1:0] mask_height_q;
	logic             mask_present_q;

	logic signed [CRD_W-1:0] px, py, amt, rw, rh, mw, mh;
	logic signed [CRD_W-1:0] bx, by, x_end, y_end;
	logic signed [CRD_W-1:0] x_lo, x_hi, y_lo, y_hi, x_last, y_last;
	logic                    is_move, outside, nonempty, need_scan, imm_hit;
	logic                    wr_in_range;

	logic [COL_W-1:0]  col_q, col_lo_q, col_last_q;
	logic [ROW_W-1:0]  row_q, row_last_q;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic              mask_mem [MEM_DEPTH];
	logic              rd_bit_q;
	logic              rd_vld_q;
	logic              acc_q;
	logic              out_valid_q;
	logic              hit_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_width_q   <= DIM_W'(RESET_MASK_DIM);
			mask_height_q  <= DIM_W'(RESET_MASK_DIM);
			mask_present_q <= 1'b0;
		end else if (cfg_wr.we) begin
			case (cfg_wr.index)
				CFG_MASK_WIDTH:   mask_width_q   <= cfg_wr.data;
				CFG_MASK_HEIGHT:  mask_height_q  <= cfg_wr.data;
				CFG_MASK_PRESENT: mask_present_q <= cfg_wr.data[0];
				default: ;
			endcase
		end
	end

	// rectangle bounds, clipping and early answers
	always_comb begin
		px  = CRD_W'($signed(item_q.pos_x));
		py  = CRD_W'($signed(item_q.pos_y));
		amt = CRD_W'($signed(item_q.move_amount));
		rw  = $signed(CRD_W'(item_q.rect_width));
		rh  = $signed(CRD_W'(item_q.rect_height));
		if (CRD_W'(mask_width_q) > CRD_W'(MAX_MASK_WIDTH)) begin
			mw = CRD_W'(MAX_MASK_WIDTH);
		end else begin
			mw = $signed(CRD_W'(mask_width_q));
		end
		if (CRD_W'(mask_height_q) > CRD_W'(MAX_MASK_HEIGHT)) begin
			mh = CRD_W'(MAX_MASK_HEIGHT);
		end else begin
			mh = $signed(CRD_W'(mask_height_q));
		end
		is_move = (item_q.func == FUNC_MOVE);
		bx = px;
		by = py;
		if (is_move) begin
			case (item_q.move_dir)
				DIR_LEFT:  bx = px - amt;
				DIR_RIGHT: bx = px + amt;
				DIR_UP:    by = py - amt;
				DIR_DOWN:  by = py + amt;
				default: ;
			endcase
		end
		x_end = bx + rw;
		y_end = by + rh;
		if (is_move) begin
			x_lo = bx;
			y_lo = by;
			x_hi = x_end;
			y_hi = y_end;
		end else begin
			x_lo = (bx < 0) ? '0 : bx;
			y_lo = (by < 0) ? '0 : by;
			x_hi = (x_end > mw) ? mw : x_end;
			y_hi = (y_end > mh) ? mh : y_end;
		end
		x_last   = x_hi - CRD_W'(1);
		y_last   = y_hi - CRD_W'(1);
		outside  = (bx < 0) || (x_end > mw) || (by < 0) || (y_end > mh);
		nonempty = (x_lo < x_hi) && (y_lo < y_hi);
		need_scan = 1'b0;
		imm_hit   = 1'b0;
		if (mask_present_q) begin
			if (!is_move) begin
				need_scan = nonempty;
			end else if (item_q.move_dir <= DIR_DOWN) begin
				if (outside) begin
					imm_hit = 1'b1;
				end else begin
					need_scan = nonempty;
				end
			end
		end
		wr_in_range = (px >= 0) && (px < CRD_W'(MAX_MASK_WIDTH)) &&
			(py >= 0) && (py < CRD_W'(MAX_MASK_HEIGHT));
	end

	assign wr_addr = ADDR_W'(px[ROW_W-1:0] & '0) +
		ADDR_W'(py[ROW_W-1:0]) * ADDR_W'(MAX_MASK_WIDTH) + ADDR_W'(px[COL_W-1:0]);
	assign rd_addr = ADDR_W'(row_q) * ADDR_W'(MAX_MASK_WIDTH) + ADDR_W'(col_q);

	// scan counters, column fastest
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			col_q      <= x_lo[COL_W-1:0];
			col_lo_q   <= x_lo[COL_W-1:0];
			col_last_q <= x_last[COL_W-1:0];
			row_q      <= y_lo[ROW_W-1:0];
			row_last_q <= y_last[ROW_W-1:0];
		end else if (cmd.step) begin
			if (col_q == col_last_q) begin
				col_q <= col_lo_q;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write && wr_in_range) begin
			mask_mem[wr_addr] <= (item_q.red == 8'd0) && (item_q.green == 8'd0) &&
				(item_q.blue == 8'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			rd_bit_q <= mask_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_q    <= 1'b0;
			acc_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_q <= cmd.step;
			if (cmd.start) begin
				acc_q <= 1'b0;
			end else if (cmd.load_imm) begin
				acc_q <= imm_hit;
			end else if (rd_vld_q) begin
				acc_q <= acc_q | rd_bit_q;
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			hit_q <= acc_q;
		end
	end

	assign sts.is_load   = (item_q.func == FUNC_LOAD);
	assign sts.is_query  = (item_q.func == FUNC_QUERY) || is_move;
	assign sts.need_scan = need_scan;
	assign sts.scan_last = (col_q == col_last_q) && (row_q == row_last_q);
	assign sts.out_free  = !out_valid_q || rsp_ready;

	assign rsp_valid = out_valid_q;
	assign rsp_hit   = hit_q;

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> !acc_q)
		else $error("hit accumulator not cleared at scan start");

	a_scan_rows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> row_q <= row_last_q)
		else $error("scan ran past the last row");

	a_no_mix: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |-> !cmd.step && !cmd.push)
		else $error("mask write overlaps scan or result");

endmodule

FILE: rtl/core/pixel_mask_collision_check.sv
// top level of the pixel collision mask checker
// load item: accepted in idle, pixel written in the cycle after, next item once setup returns to idle
// query: setup, then scan and last when pixels are scanned, else straight to done, where the result is registered
// next item accepted once the result is registered; a stalled earlier result holds a query in done
// reset: width and height 1024, mask absent; mask contents undefined until loaded
module pixel_mask_collision_check (
	input logic        clk,
	input logic        arst_n,
	pmcc_req_if.sink   req,
	pmcc_rsp_if.source rsp,
	pmcc_cfg_if.sink   cfg
);
	import pmcc_pkg::*;

	req_item_t item;
	cfg_wr_t   cfg_wr;
	dp_cmd_t   cmd;
	dp_sts_t   sts;
	logic      in_ready;

	assign item = '{
		func:        req.func,
		pos_x:       req.pos_x,
		pos_y:       req.pos_y,
		rect_width:  req.rect_width,
		rect_height: req.rect_height,
		move_dir:    req.move_dir,
		move_amount: req.move_amount,
		red:         req.red,
		green:       req.green,
		blue:        req.blue
	};

	assign cfg.ready    = 1'b1;
	assign cfg_wr.we    = cfg.valid;
	assign cfg_wr.index = cfg.index;
	assign cfg_wr.data  = cfg.data;

	assign req.ready = in_ready;

	pmcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pmcc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_wr    (cfg_wr),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.rsp_hit   (rsp.hit)
	);

endmodule

FILE: tb/sv/testbench.sv
// testbench of the collision mask checker: random pixel loads and rectangle queries checked against a predictor
module testbench;
	import pmcc_pkg::*;

	localparam int TILE         = 24;
	localparam int CORNER_X     = MAX_MASK_WIDTH - 8;
	localparam int CORNER_Y     = MAX_MASK_HEIGHT - 8;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 150;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pmcc_req_if req_bus ();
	pmcc_rsp_if rsp_bus ();
	pmcc_cfg_if cfg_bus ();

	pixel_mask_collision_check DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	// register copies, reset values
	logic [DIM_W-1:0] mask_w = RESET_MASK_DIM;
	logic [DIM_W-1:0] mask_h = RESET_MASK_DIM;
	logic             mask_on = 1'b0;

	// phase settings, extremes included
	logic [DIM_W-1:0] ph_w [PHASES] = '{24, 2047, 1, 0, 20, 24, 1024, 17};
	logic [DIM_W-1:0] ph_h [PHASES] = '{24, 1024, 24, 0, 1, 24, 1024, 23};
	logic             ph_on [PHASES] = '{1, 1, 1, 1, 1, 0, 1, 1};

	bit blocked_map [MEM_DEPTH];
	bit loaded_map [MEM_DEPTH];

	req_item_t pending_items [$];
	bit        expected_hits [$];
	req_item_t on_bus;

	int errors = 0;
	int n_loads = 0;
	int n_queries = 0;
	int n_hits = 0;
	int idle_left = 0;
	int stall_left = 0;
	bit drv_burst = 1'b0;
	bit rsp_burst = 1'b0;
	bit want_hit;

	always #2 clk = ~clk;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic req_item_t rand_fields();
		req_item_t it;
		it.func        = FUNC_NONE;
		it.pos_x       = $urandom;
		it.pos_y       = $urandom;
		it.rect_width  = $urandom;
		it.rect_height = $urandom;
		it.move_dir    = $urandom;
		it.move_amount = $urandom;
		it.red         = $urandom;
		it.green       = $urandom;
		it.blue        = $urandom;
		return it;
	endfunction

	function automatic logic [23:0] pixel_color();
		logic [23:0] c;
		if ($urandom_range(0, 4) == 0) return '0;
		do c = $urandom; while (c == '0);
		return c;
	endfunction

	// pixel box a query reads; off_mask set when a move leaves the mask
	function automatic bit scan_box(input req_item_t it, output int x0, output int y0,
			output int x1, output int y1, output bit off_mask);
		int mw, mh, nx, ny, rw, rh, amt;
		mw = (mask_w > MAX_MASK_WIDTH) ? MAX_MASK_WIDTH : mask_w;
		mh = (mask_h > MAX_MASK_HEIGHT) ? MAX_MASK_HEIGHT : mask_h;
		nx = it.pos_x;
		ny = it.pos_y;
		rw = it.rect_width;
		rh = it.rect_height;
		amt = it.move_amount;
		x0 = 0;
		y0 = 0;
		x1 = 0;
		y1 = 0;
		off_mask = 1'b0;
		if (it.func == FUNC_QUERY) begin
			x0 = (nx < 0) ? 0 : nx;
			y0 = (ny < 0) ? 0 : ny;
			x1 = (nx + rw > mw) ? mw : nx + rw;
			y1 = (ny + rh > mh) ? mh : ny + rh;
			return 1'b1;
		end
		if (it.func != FUNC_MOVE || it.move_dir > DIR_DOWN) return 1'b0;
		case (it.move_dir)
			DIR_LEFT:  nx = nx - amt;
			DIR_RIGHT: nx = nx + amt;
			DIR_UP:    ny = ny - amt;
			default:   ny = ny + amt;
		endcase
		if (nx < 0 || nx + rw > mw || ny < 0 || ny + rh > mh) begin
			off_mask = 1'b1;
			return 1'b0;
		end
		x0 = nx;
		y0 = ny;
		x1 = nx + rw;
		y1 = ny + rh;
		return 1'b1;
	endfunction

	task automatic collision_predict(input req_item_t it);
		int x0, y0, x1, y1, x, y;
		bit off, hit;
		case (it.func)
			FUNC_LOAD: begin
				x = it.pos_x;
				y = it.pos_y;
				if (x >= 0 && x < MAX_MASK_WIDTH && y >= 0 && y < MAX_MASK_HEIGHT)
					blocked_map[y * MAX_MASK_WIDTH + x] =
						(it.red == 0 && it.green == 0 && it.blue == 0);
				n_loads++;
			end
			FUNC_QUERY, FUNC_MOVE: begin
				hit = 1'b0;
				if (mask_on) begin
					if (scan_box(it, x0, y0, x1, y1, off)) begin
						for (x = x0; x < x1 && !hit; x++)
							for (y = y0; y < y1 && !hit; y++)
								hit = blocked_map[y * MAX_MASK_WIDTH + x];
					end else begin
						hit = off;
					end
				end
				expected_hits.push_back(hit);
				n_queries++;
			end
			default: ;
		endcase
	endtask

	task automatic queue_load(input int x, input int y, input logic [23:0] rgb);
		req_item_t it;
		it = rand_fields();
		it.func = FUNC_LOAD;
		it.pos_x = x;
		it.pos_y = y;
		{it.red, it.green, it.blue} = rgb;
		if (x >= 0 && x < MAX_MASK_WIDTH && y >= 0 && y < MAX_MASK_HEIGHT)
			loaded_map[y * MAX_MASK_WIDTH + x] = 1'b1;
		pending_items.push_back(it);
	endtask

	task automatic queue_req(input func_t f, input int px, input int py, input int rw,
			input int rh, input logic [2:0] dir, input int amt);
		req_item_t it;
		it = rand_fields();
		it.func = f;
		it.pos_x = px;
		it.pos_y = py;
		it.rect_width = rw;
		it.rect_height = rh;
		it.move_dir = dir;
		it.move_amount = amt;
		pending_items.push_back(it);
	endtask

	task automatic queue_rand_load();
		int sel;
		logic [23:0] rgb;
		sel = $urandom_range(0, 9);
		rgb = pixel_color();
		if (sel < 6)
			queue_load($urandom_range(0, TILE - 1), $urandom_range(0, TILE - 1), rgb);
		else if (sel < 7)
			queue_load(CORNER_X + $urandom_range(0, 7), CORNER_Y + $urandom_range(0, 7), rgb);
		else if (sel < 8)
			queue_load($urandom_range(0, MAX_MASK_WIDTH - 1),
				$urandom_range(0, MAX_MASK_HEIGHT - 1), rgb);
		else if (sel < 9)
			queue_load(-int'($urandom_range(1, 2048)), $urandom_range(0, 2047), rgb);
		else
			queue_load($urandom_range(MAX_MASK_WIDTH, 2047), $urandom_range(0, 4095) - 2048, rgb);
	endtask

	// random query that only reads loaded pixels
	task automatic queue_query(input int bx, input int by);
		req_item_t it;
		int x0, y0, x1, y1, x, y, tries;
		bit off, ok;
		ok = 1'b0;
		for (tries = 0; tries < 200 && !ok; tries++) begin
			it = rand_fields();
			it.func = $urandom_range(0, 1) ? FUNC_QUERY : FUNC_MOVE;
			if ($urandom_range(0, 3) != 0) begin
				it.pos_x = bx + $urandom_range(0, 28) - 4;
				it.pos_y = by + $urandom_range(0, 28) - 4;
				it.rect_width = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 8) : $urandom_range(9, 28);
				it.rect_height = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 8) : $urandom_range(9, 28);
				it.move_dir = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 3) : $urandom_range(4, 7);
				it.move_amount = $urandom_range(0, 16) - 8;
			end
			ok = 1'b1;
			if (scan_box(it, x0, y0, x1, y1, off))
				for (x = x0; x < x1 && ok; x++)
					for (y = y0; y < y1 && ok; y++)
						if (!loaded_map[y * MAX_MASK_WIDTH + x]) ok = 1'b0;
		end
		if (!ok) it.rect_width = 0;
		pending_items.push_back(it);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [DIM_W-1:0] val);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= val;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		case (idx)
			CFG_MASK_WIDTH:   mask_w = val;
			CFG_MASK_HEIGHT:  mask_h = val;
			CFG_MASK_PRESENT: mask_on = val[0];
			default: ;
		endcase
	endtask

	task automatic drain();
		do @(negedge clk);
		while (pending_items.size() != 0 || req_bus.valid || expected_hits.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	// item driver
	always @(posedge clk) begin
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
		end else begin
			if (req_bus.valid && req_bus.ready) begin
				collision_predict(on_bus);
				idle_left = drv_burst ? 0 : gap_len();
				if ($urandom_range(0, 149) == 0) drv_burst = !drv_burst;
			end
			if (!req_bus.valid || req_bus.ready) begin
				if (idle_left == 0 && pending_items.size() != 0) begin
					on_bus = pending_items.pop_front();
					req_bus.valid       <= 1'b1;
					req_bus.func        <= on_bus.func;
					req_bus.pos_x       <= on_bus.pos_x;
					req_bus.pos_y       <= on_bus.pos_y;
					req_bus.rect_width  <= on_bus.rect_width;
					req_bus.rect_height <= on_bus.rect_height;
					req_bus.move_dir    <= on_bus.move_dir;
					req_bus.move_amount <= on_bus.move_amount;
					req_bus.red         <= on_bus.red;
					req_bus.green       <= on_bus.green;
					req_bus.blue        <= on_bus.blue;
				end else begin
					req_bus.valid <= 1'b0;
					if (idle_left != 0) idle_left--;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
		end else begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (expected_hits.size() == 0) begin
					errors++;
					$display("%0t: result with nothing expected, expected none, got hit %0b",
						$time, rsp_bus.hit);
				end else begin
					want_hit = expected_hits.pop_front();
					if (rsp_bus.hit !== want_hit) begin
						errors++;
						$display("%0t: hit mismatch, expected %0b, got %0b",
							$time, want_hit, rsp_bus.hit);
					end
					if (want_hit) n_hits++;
				end
			end
			if (stall_left != 0) begin
				rsp_bus.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_bus.ready <= 1'b1;
				if (!rsp_burst && $urandom_range(0, 4) == 0) stall_left = gap_len();
			end
			if ($urandom_range(0, 299) == 0) rsp_burst = !rsp_burst;
		end
	end

	initial begin
		#30000000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int ph, n, x, y, sel, bx, by;
		logic [23:0] first_colors [5];
		first_colors = '{24'hFFFFFF, 24'h000001, 24'h010000, 24'h008000, 24'h000000};
		req_bus.valid = 1'b0;
		req_bus.func = FUNC_NONE;
		req_bus.pos_x = '0;
		req_bus.pos_y = '0;
		req_bus.rect_width = '0;
		req_bus.rect_height = '0;
		req_bus.move_dir = '0;
		req_bus.move_amount = '0;
		req_bus.red = '0;
		req_bus.green = '0;
		req_bus.blue = '0;
		rsp_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = CFG_MASK_WIDTH;
		cfg_bus.data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: no mask, nothing loaded yet
		queue_req(FUNC_QUERY, 0, 0, 0, 7, DIR_LEFT, 0);
		queue_req(FUNC_QUERY, -5, -5, 5, 5, DIR_LEFT, 0);
		queue_req(FUNC_MOVE, 0, 0, 3, 3, DIR_LEFT, 5);
		queue_req(FUNC_MOVE, 0, 0, 3, 3, 3'd6, 2);
		queue_req(FUNC_NONE, 3, 3, 2, 2, DIR_UP, 1);
		queue_load(-2048, 0, 24'h0);
		queue_load(2047, 2047, 24'h0);
		queue_load(MAX_MASK_WIDTH, 5, 24'h0);
		queue_load(5, -1, 24'h0);
		for (y = 0; y < TILE; y++)
			for (x = 0; x < TILE; x++)
				queue_load(x, y, (y == 0 && x < 5) ? first_colors[x] : pixel_color());
		for (y = CORNER_Y; y < MAX_MASK_HEIGHT; y++)
			for (x = CORNER_X; x < MAX_MASK_WIDTH; x++)
				queue_load(x, y, pixel_color());
		drain();

		for (ph = 0; ph < PHASES; ph++) begin
			write_reg(CFG_MASK_WIDTH, ph_w[ph]);
			write_reg(CFG_MASK_HEIGHT, ph_h[ph]);
			write_reg(CFG_MASK_PRESENT, ph_on[ph]);
			if (ph == 0) write_reg(CFG_UNUSED, $urandom);
			@(negedge clk);
			if (ph == 0) begin
				queue_req(FUNC_QUERY, -999, -999, 1023, 1023, DIR_LEFT, 0);
				queue_req(FUNC_QUERY, 2047, 2047, 5, 5, DIR_LEFT, 0);
				queue_req(FUNC_QUERY, 23, 23, 1023, 1023, DIR_LEFT, 0);
				queue_req(FUNC_MOVE, 0, 0, 4, 4, DIR_RIGHT, 1023);
				queue_req(FUNC_MOVE, 5, 5, 4, 4, DIR_UP, -1024);
				for (n = 4; n < 8; n++)
					queue_req(FUNC_MOVE, 5, 5, 4, 4, n, $urandom_range(0, 2047));
				queue_req(FUNC_MOVE, 10, 10, 0, 0, DIR_LEFT, 3);
				queue_req(FUNC_MOVE, 0, 10, 0, 3, DIR_LEFT, 1);
				queue_req(FUNC_MOVE, 20, 20, 4, 4, DIR_DOWN, 0);
				queue_req(FUNC_MOVE, 20, 20, 4, 4, DIR_RIGHT, 1);
				queue_req(FUNC_MOVE, 8, 8, 3, 3, DIR_LEFT, -2);
				queue_req(FUNC_MOVE, 8, 8, 3, 3, DIR_UP, 2);
			end
			for (n = 0; n < PHASE_ITEMS; n++) begin
				sel = $urandom_range(0, 99);
				if (sel < 75) begin
					bx = 0;
					by = 0;
					if (mask_w >= MAX_MASK_WIDTH && mask_h >= MAX_MASK_HEIGHT && $urandom_range(0, 1)) begin
						bx = CORNER_X;
						by = CORNER_Y;
					end
					queue_query(bx, by);
				end else if (sel < 97) begin
					queue_rand_load();
				end else begin
					pending_items.push_back(rand_fields());
				end
			end
			drain();
		end

		repeat (16) @(posedge clk);
		$display("run covered %0d pixel loads and %0d queries (%0d hits) over %0d mask settings",
			n_loads, n_queries, n_hits, PHASES + 1);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: pixel_mask_collision_check.f
rtl/core/pmcc_pkg.sv
rtl/core/pmcc_channels.sv
rtl/core/pmcc_ctrl.sv
rtl/core/pmcc_dp.sv
rtl/core/pixel_mask_collision_check.sv
tb/sv/testbench.sv
